/* sv/affine_vertex_transform_defines.svh */
// assertion helpers used by the vertex transform top module
`ifndef AFFINE_VERTEX_TRANSFORM_DEFINES_SVH
`define AFFINE_VERTEX_TRANSFORM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AVT_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("vertex transform check failed");

// next-cycle implication, checked outside reset
`define AVT_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

`endif

/* sv/avt_pkg.sv */
`default_nettype none

package avt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 64;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int TOTAL_W       = SUM_W + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int STAGES        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      is_vector;
    } vertex_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] qz;
    } vertex_out_t;

    // one matrix column: weights for x, y, z and the translation term
    typedef struct packed {
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic signed [COORD_W-1:0] mz;
        logic signed [COORD_W-1:0] trans;
    } column_t;

    typedef struct packed {
        column_t col_x;
        column_t col_y;
        column_t col_z;
    } matrix_t;

endpackage

`default_nettype wire

/* sv/affine_vertex_transform.sv */
// a request taken at a clock edge is registered in turn by the multiply, sum
// and shift, and translate and saturate stages; its result shows with strobe
// throughput: one request per clock when not busy, via pipelined column lanes
// reset: rst_n clears the stage valid bits and loads the identity matrix;
// busy is high during reset and the cycle after; the receiver cannot stall
`default_nettype none
`include "affine_vertex_transform_defines.svh"

module affine_vertex_transform #(
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire avt_pkg::vertex_in_t           req,
    input  wire logic                          cfg_we,
    input  wire logic [avt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [avt_pkg::CFG_W-1:0]     cfg_data,
    output logic                               strobe,
    output avt_pkg::vertex_out_t               result
);
    import avt_pkg::*;

    logic               ready_reg;
    logic               accept;
    logic [STAGES-1:0]  vld_reg, vld_next;
    logic [STAGES-1:0]  load;
    matrix_t            matrix;
    logic signed [COORD_W-1:0] qx, qy, qz;

    assign accept   = start && ready_reg;
    assign vld_next = {vld_reg[STAGES-2:0], accept};
    assign load     = vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            vld_reg   <= '0;
        end
        else
        begin
            ready_reg <= 1'b1;
            vld_reg   <= vld_next;
        end
    end

    avt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix)
    );

    avt_column #(
        .FRAC_BITS (FRAC_BITS)
    ) u_col_x (
        .clk  (clk),
        .load (load),
        .vin  (req),
        .col  (matrix.col_x),
        .q    (qx)
    );

    avt_column #(
        .FRAC_BITS (FRAC_BITS)
    ) u_col_y (
        .clk  (clk),
        .load (load),
        .vin  (req),
        .col  (matrix.col_y),
        .q    (qy)
    );

    avt_column #(
        .FRAC_BITS (FRAC_BITS)
    ) u_col_z (
        .clk  (clk),
        .load (load),
        .vin  (req),
        .col  (matrix.col_z),
        .q    (qz)
    );

    assign busy      = !ready_reg;
    assign strobe    = vld_reg[STAGES-1];
    assign result.qx = qx;
    assign result.qy = qy;
    assign result.qz = qz;

    `AVT_ASSERT_IMPL(a_req_to_result, clk, rst_n, start && !busy, ##3 strobe)
    `AVT_ASSERT_IMPL(a_result_has_req, clk, rst_n, strobe, $past(start && !busy, 3))
    `AVT_ASSERT_NEXT(a_ready_holds, clk, rst_n, !busy, !busy)

endmodule

`default_nettype wire

/* sv/avt_cfg_regs.sv */
`default_nettype none

module avt_cfg_regs #(
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [avt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [avt_pkg::CFG_W-1:0]     cfg_data,
    output avt_pkg::matrix_t                   matrix
);
    import avt_pkg::*;

    localparam logic [CFG_W-1:0] ONE_FX = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] x_low_reg,  x_low_next;
    logic [CFG_W-1:0] x_high_reg, x_high_next;
    logic [CFG_W-1:0] y_low_reg,  y_low_next;
    logic [CFG_W-1:0] y_high_reg, y_high_next;
    logic [CFG_W-1:0] z_low_reg,  z_low_next;
    logic [CFG_W-1:0] z_high_reg, z_high_next;

    always_comb
    begin
        x_low_next  = x_low_reg;
        x_high_next = x_high_reg;
        y_low_next  = y_low_reg;
        y_high_next = y_high_reg;
        z_low_next  = z_low_reg;
        z_high_next = z_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_LOW:  x_low_next  = cfg_data;
                REG_X_HIGH: x_high_next = cfg_data;
                REG_Y_LOW:  y_low_next  = cfg_data;
                REG_Y_HIGH: y_high_next = cfg_data;
                REG_Z_LOW:  z_low_next  = cfg_data;
                REG_Z_HIGH: z_high_next = cfg_data;
                default:    ;
            endcase
        end
    end

    // reset to the identity matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= ONE_FX;
            x_high_reg <= '0;
            y_low_reg  <= ONE_FX << COORD_W;
            y_high_reg <= '0;
            z_low_reg  <= '0;
            z_high_reg <= ONE_FX;
        end
        else
        begin
            x_low_reg  <= x_low_next;
            x_high_reg <= x_high_next;
            y_low_reg  <= y_low_next;
            y_high_reg <= y_high_next;
            z_low_reg  <= z_low_next;
            z_high_reg <= z_high_next;
        end
    end

    assign matrix.col_x = {x_low_reg[COORD_W-1:0], x_low_reg[CFG_W-1:COORD_W],
                           x_high_reg[COORD_W-1:0], x_high_reg[CFG_W-1:COORD_W]};
    assign matrix.col_y = {y_low_reg[COORD_W-1:0], y_low_reg[CFG_W-1:COORD_W],
                           y_high_reg[COORD_W-1:0], y_high_reg[CFG_W-1:COORD_W]};
    assign matrix.col_z = {z_low_reg[COORD_W-1:0], z_low_reg[CFG_W-1:COORD_W],
                           z_high_reg[COORD_W-1:0], z_high_reg[CFG_W-1:COORD_W]};

endmodule

`default_nettype wire

/* sv/avt_column.sv */
`default_nettype none

module avt_column #(
    parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic [avt_pkg::STAGES-1:0]         load,
    input  wire avt_pkg::vertex_in_t                vin,
    input  wire avt_pkg::column_t                   col,
    output logic signed [avt_pkg::COORD_W-1:0]      q
);
    import avt_pkg::*;

    localparam logic signed [TOTAL_W-1:0] SAT_MAX = TOTAL_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [TOTAL_W-1:0] SAT_MIN = -SAT_MAX - TOTAL_W'(1);

    // stage 1: three products
    logic signed [PROD_W-1:0] pa_reg, pa_next;
    logic signed [PROD_W-1:0] pb_reg, pb_next;
    logic signed [PROD_W-1:0] pc_reg, pc_next;
    logic                     vec1_reg;
    // stage 2: exact sum, floor shift
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  shr_reg, shr_next;
    logic                     vec2_reg;
    // stage 3: translation (points only) and saturation
    logic signed [TOTAL_W-1:0] total;
    logic signed [COORD_W-1:0] q_reg, q_next;

    always_comb
    begin
        pa_next = PROD_W'(vin.px) * PROD_W'(col.mx);
        pb_next = PROD_W'(vin.py) * PROD_W'(col.my);
        pc_next = PROD_W'(vin.pz) * PROD_W'(col.mz);
    end

    // summing the products before the shift gives the same floor as the split sums
    always_comb
    begin
        sum_next = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(pc_reg);
        shr_next = sum_next >>> FRAC_BITS;
    end

    always_comb
    begin
        total = TOTAL_W'(shr_reg);
        if (!vec2_reg)
        begin
            total = total + TOTAL_W'(col.trans);
        end
        if (total > SAT_MAX)
        begin
            q_next = SAT_MAX[COORD_W-1:0];
        end
        else if (total < SAT_MIN)
        begin
            q_next = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            q_next = total[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            vec1_reg <= vin.is_vector;
        end
        if (load[1])
        begin
            shr_reg  <= shr_next;
            vec2_reg <= vec1_reg;
        end
        if (load[2])
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* test/tb_affine_vertex_transform.sv */
`default_nettype none

module tb_affine_vertex_transform;

    import avt_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 160;
    localparam int MATRIX_TRIES = 7;

    // indexes past the last column register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [TOTAL_W-1:0] SUM_MAX = 67'sh7FFF_FFFF;
    localparam logic signed [TOTAL_W-1:0] SUM_MIN = -67'sh8000_0000;

    localparam logic [COORD_W-1:0] Q_ONE = 32'h0001_0000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    vertex_in_t           req       = '0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 strobe;
    vertex_out_t          result;

    vertex_in_t  pending_vertices[$];
    vertex_out_t expected_vertices[$];
    logic [CFG_W-1:0] matrix_regs [0:5];

    bit took;
    int sent_count;
    int mismatch_count;
    int cycle_count;

    affine_vertex_transform DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .result    (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // exact sum of products, floor shift, optional translation, saturation
    function automatic logic signed [COORD_W-1:0] column_dot(vertex_in_t v,
                                                             logic [CFG_W-1:0] lo,
                                                             logic [CFG_W-1:0] hi);
        logic signed [SUM_W-1:0]   acc;
        logic signed [TOTAL_W-1:0] total;
        acc = SUM_W'($signed(v.px)) * SUM_W'($signed(lo[31:0]))
            + SUM_W'($signed(v.py)) * SUM_W'($signed(lo[63:32]))
            + SUM_W'($signed(v.pz)) * SUM_W'($signed(hi[31:0]));
        total = TOTAL_W'(acc >>> FRAC_BITS_DEF);
        if (!v.is_vector)
            total = total + TOTAL_W'($signed(hi[63:32]));
        if (total > SUM_MAX)
            return 32'sh7FFF_FFFF;
        if (total < SUM_MIN)
            return 32'sh8000_0000;
        return total[COORD_W-1:0];
    endfunction

    function automatic vertex_out_t transform_vertex(vertex_in_t v);
        vertex_out_t r;
        r.qx = column_dot(v, matrix_regs[REG_X_LOW], matrix_regs[REG_X_HIGH]);
        r.qy = column_dot(v, matrix_regs[REG_Y_LOW], matrix_regs[REG_Y_HIGH]);
        r.qz = column_dot(v, matrix_regs[REG_Z_LOW], matrix_regs[REG_Z_HIGH]);
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] edge_value();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return Q_ONE;
        endcase
    endfunction

    // mostly within +-512.0 so that sums stay in range; some full range and edges
    function automatic logic [COORD_W-1:0] random_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return edge_value();
            default:
            begin
                v = $urandom_range(0, 67108863);
                return v - 33554432;
            end
        endcase
    endfunction

    // matrix entries mostly within +-8.0
    function automatic logic [COORD_W-1:0] random_entry();
        int v;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return edge_value();
            default:
            begin
                v = $urandom_range(0, 1048575);
                return v - 524288;
            end
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic push_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z, logic is_vec);
        vertex_in_t v;
        v.px = x;
        v.py = y;
        v.pz = z;
        v.is_vector = is_vec;
        pending_vertices.push_back(v);
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() != 0 || start || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (STAGES + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= REG_Z_HIGH)
            matrix_regs[idx] = val;
    endtask

    task automatic load_matrix(logic [CFG_W-1:0] xl, logic [CFG_W-1:0] xh,
                               logic [CFG_W-1:0] yl, logic [CFG_W-1:0] yh,
                               logic [CFG_W-1:0] zl, logic [CFG_W-1:0] zh);
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        write_reg(REG_Z_LOW, zl);
        write_reg(REG_Z_HIGH, zh);
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int count);
        repeat (count)
            push_vertex(random_coord(), random_coord(), random_coord(),
                        1'($urandom_range(0, 1)));
    endtask

    // feeds requests; a request stays up until taken
    always @(negedge clk)
    begin
        if (rst_n && (took || !start))
        begin
            if (pending_vertices.size() != 0 &&
                ((sent_count >= 400 && sent_count < 650) || $urandom_range(0, 99) >= 11))
            begin
                req   <= pending_vertices.pop_front();
                start <= 1'b1;
                sent_count++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        vertex_out_t want;
        took = rst_n && start && !busy;
        if (took)
            expected_vertices.push_back(transform_vertex(req));
        if (rst_n && strobe)
        begin
            if (expected_vertices.size() == 0)
            begin
                report_mismatch("result with no request pending", result.qx, '0);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (result.qx !== want.qx)
                    report_mismatch("qx", result.qx, want.qx);
                if (result.qy !== want.qy)
                    report_mismatch("qy", result.qy, want.qy);
                if (result.qz !== want.qz)
                    report_mismatch("qz", result.qz, want.qz);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // identity after reset
        matrix_regs[REG_X_LOW]  = {32'h0, Q_ONE};
        matrix_regs[REG_X_HIGH] = '0;
        matrix_regs[REG_Y_LOW]  = {Q_ONE, 32'h0};
        matrix_regs[REG_Y_HIGH] = '0;
        matrix_regs[REG_Z_LOW]  = '0;
        matrix_regs[REG_Z_HIGH] = {32'h0, Q_ONE};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset matrix: field extremes and tiny negatives
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_vertex(Q_ONE, 32'hFFFF_0000, 32'h0000_8000, 1'b1);
        push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        push_vertex(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0);
        wait_drained();

        // largest entries and translations: saturation both ways
        load_matrix({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                    {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1);
        push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        wait_drained();

        load_matrix({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                    {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}});
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        push_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
        push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        wait_drained();

        // all-ones entries (tiny negatives) and an all-zero column
        load_matrix({64{1'b1}}, {64{1'b1}}, '0, '0, {64{1'b1}}, '0);
        push_vertex(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0);
        push_vertex(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        push_vertex(Q_ONE, Q_ONE, Q_ONE, 1'b1);
        wait_drained();

        repeat (MATRIX_TRIES)
        begin
            load_matrix({random_entry(), random_entry()}, {random_entry(), random_entry()},
                        {random_entry(), random_entry()}, {random_entry(), random_entry()},
                        {random_entry(), random_entry()}, {random_entry(), random_entry()});
            queue_random(RANDOM_ITEMS);
            wait_drained();
        end

        if (mismatch_count == 0 && expected_vertices.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
